FILE: src/whbld_pkg.sv
// Shared types, constants and helper functions for the weighted-path UDP/IPv4
// header builder. No dependencies.
`default_nettype none

package whbld_pkg;

    // Fixed widths and limits
    localparam int unsigned MAX_PATHS  = 5;
    localparam int unsigned CUM_REGS   = 4;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [9:0]  PER_MILLE   = 10'd1000;
    localparam logic [10:0] HDR_FIXED   = 11'd42;
    localparam logic [10:0] MIN_PAYLOAD = 11'd10;
    localparam logic [10:0] IP_UDP_HDRS = 11'd28;
    localparam logic [10:0] UDP_HDR     = 11'd8;
    localparam logic [15:0] PROTO_UDP   = 16'd17;

    // Fixed IPv4 header words: ver/ihl/tos, ident 54321, flags/frag 0, ttl 64/proto 17
    localparam logic [18:0] IP_FIXED_SUM = 19'h04500 + 19'd54321 + 19'h04011;

    // Reset values
    localparam logic [15:0] PORT_BASE_RST  = 16'd8000;
    localparam logic [2:0]  PATH_COUNT_RST = 3'd1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SRC_IP     = 3'd0,
        REG_DST_IP     = 3'd1,
        REG_PORT_BASE  = 3'd2,
        REG_PATH_COUNT = 3'd3,
        REG_CUM_1      = 3'd4,
        REG_CUM_2      = 3'd5,
        REG_CUM_3      = 3'd6,
        REG_CUM_4      = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [31:0]               src_ip;
        logic [31:0]               dst_ip;
        logic [15:0]               port_base;
        logic [2:0]                path_count;
        logic [CUM_REGS-1:0][9:0]  cum;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  path_id;
        logic [15:0] src_port;
        logic [10:0] ip_total_len;
        logic [15:0] ip_checksum;
        logic [10:0] udp_len;
        logic [15:0] udp_checksum;
    } res_t;

    // Two end-around-carry folds, then invert.
    function automatic logic [15:0] csum_fold(input logic [18:0] s);
        logic [16:0] a;
        logic [16:0] b;
        a = 17'(s[18:16]) + 17'(s[15:0]);
        b = 17'(a[16]) + 17'(a[15:0]);
        return ~b[15:0];
    endfunction

    // Last path whose closed interval [cum(i), cum(i+1)] holds r; 0 if none.
    // Bounds past the usable count sit at 1000.
    function automatic logic [2:0] choose_path(input logic [9:0] r, input cfg_t cfg);
        logic [2:0]                 cnt;
        logic [MAX_PATHS:0][9:0]    bnd;
        logic [2:0]                 pick;
        cnt    = (cfg.path_count > 3'(MAX_PATHS)) ? 3'(MAX_PATHS) : cfg.path_count;
        pick   = '0;
        bnd    = {(MAX_PATHS + 1){PER_MILLE}};
        bnd[0] = '0;
        for (int i = 0; i < CUM_REGS; i++)
        begin
            if (3'(i + 1) < cnt)
            begin
                bnd[i+1] = (cfg.cum[i] > PER_MILLE) ? PER_MILLE : cfg.cum[i];
            end
        end
        for (int i = 0; i < MAX_PATHS; i++)
        begin
            if ((3'(i) < cnt) && (r >= bnd[i]) && (r <= bnd[i+1]))
            begin
                pick = 3'(i);
            end
        end
        return pick;
    endfunction

endpackage

`default_nettype wire

FILE: src/whbld_cfg_regs.sv
// Configuration register file for the header builder.
// Depends on whbld_pkg.
`default_nettype none

module whbld_cfg_regs
    import whbld_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                       cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_SRC_IP:     cfg_next.src_ip     = cfg_data;
                REG_DST_IP:     cfg_next.dst_ip     = cfg_data;
                REG_PORT_BASE:  cfg_next.port_base  = cfg_data[15:0];
                REG_PATH_COUNT: cfg_next.path_count = cfg_data[2:0];
                REG_CUM_1:      cfg_next.cum[0]     = cfg_data[9:0];
                REG_CUM_2:      cfg_next.cum[1]     = cfg_data[9:0];
                REG_CUM_3:      cfg_next.cum[2]     = cfg_data[9:0];
                REG_CUM_4:      cfg_next.cum[3]     = cfg_data[9:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.src_ip     <= '0;
            cfg_reg.dst_ip     <= '0;
            cfg_reg.port_base  <= PORT_BASE_RST;
            cfg_reg.path_count <= PATH_COUNT_RST;
            cfg_reg.cum        <= {CUM_REGS{PER_MILLE}};
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

FILE: src/whbld_hdr_calc.sv
// Single-pass header math: path pick, ports, lengths, both checksums.
// Depends on whbld_pkg.
`default_nettype none

module whbld_hdr_calc
    import whbld_pkg::*;
(
    input  wire cfg_t         cfg,
    input  wire logic [9:0]   rand_value,
    input  wire logic [10:0]  pkt_len,
    input  wire logic [15:0]  dst_port,
    output res_t              res
);

    logic [2:0]  path;
    logic [15:0] sport;
    logic [10:0] payload;
    logic [10:0] tot;
    logic [10:0] ulen;
    logic [17:0] addr_sum;
    logic [18:0] ip_sum;
    logic [18:0] udp_sum;
    logic [15:0] udp_fold;

    always_comb
    begin
        path    = choose_path(rand_value, cfg);
        sport   = cfg.port_base + 16'(path);
        // short frames clamp to the minimum payload
        payload = (pkt_len > (HDR_FIXED + MIN_PAYLOAD)) ? (pkt_len - HDR_FIXED) : MIN_PAYLOAD;
        tot     = payload + IP_UDP_HDRS;
        ulen    = payload + UDP_HDR;

        addr_sum = 18'(cfg.src_ip[31:16]) + 18'(cfg.src_ip[15:0])
                 + 18'(cfg.dst_ip[31:16]) + 18'(cfg.dst_ip[15:0]);

        ip_sum  = IP_FIXED_SUM + 19'(tot) + 19'(addr_sum);
        udp_sum = 19'(addr_sum) + 19'(PROTO_UDP) + 19'(ulen) + 19'(ulen)
                + 19'(sport) + 19'(dst_port);
        udp_fold = csum_fold(udp_sum);

        res.path_id      = path;
        res.src_port     = sport;
        res.ip_total_len = tot;
        res.ip_checksum  = csum_fold(ip_sum);
        res.udp_len      = ulen;
        // zero UDP checksum means "none", so send all ones instead
        res.udp_checksum = (udp_fold == 16'h0000) ? 16'hffff : udp_fold;
    end

endmodule

`default_nettype wire

FILE: src/weighted_path_udp_header_builder.sv
// Weighted multipath UDP/IPv4 header builder. Each request word (rand_value,
// pkt_len, dst_port) yields one result word: the chosen path (last path whose
// per-mille interval holds rand_value, 0 if none), the source port
// port_base + path, IPv4 total length and UDP length for a zero payload of
// max(pkt_len - 42, 10) bytes, the IPv4 header checksum and the UDP checksum
// (pseudo-header plus UDP header; a zero result is sent as 0xFFFF).
// Two register stages: the input register, then the full header math in one
// combinational pass into the result register. An accepted word moves on
// into the result register once that register is empty or being drained,
// and out_valid then rises. Throughput is one word per clock while out_stall
// is low; the input stage keeps accepting while a result waits, and in_stall
// rises only when both stages are full and out_stall is high. Configuration
// registers (cfg_index 0..7: src_ip, dst_ip, port_base, path_count,
// cum_threshold_1..4) are written through cfg_we and must be changed only while
// no word is in flight.
// Depends on whbld_pkg, whbld_cfg_regs, whbld_hdr_calc.
`default_nettype none

module weighted_path_udp_header_builder
    import whbld_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // configuration write port
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    // request channel
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic [9:0]            rand_value,
    input  wire logic [10:0]           pkt_len,
    input  wire logic [15:0]           dst_port,
    // result channel
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [2:0]                 path_id,
    output logic [15:0]                src_port,
    output logic [10:0]                ip_total_len,
    output logic [15:0]                ip_checksum,
    output logic [10:0]                udp_len,
    output logic [15:0]                udp_checksum
);

    cfg_t cfg;
    res_t calc_res;

    // input stage
    logic        s1_valid_reg;
    logic        s1_valid_next;
    logic [9:0]  s1_rand_reg;
    logic [10:0] s1_len_reg;
    logic [15:0] s1_dport_reg;

    // result stage
    logic        s2_valid_reg;
    logic        s2_valid_next;
    res_t        s2_res_reg;

    logic        in_take;
    logic        s2_load;

    whbld_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    whbld_hdr_calc u_hdr_calc (
        .cfg        (cfg),
        .rand_value (s1_rand_reg),
        .pkt_len    (s1_len_reg),
        .dst_port   (s1_dport_reg),
        .res        (calc_res)
    );

    // Result register can take a new word when empty or being drained.
    assign s2_load  = !s2_valid_reg || !out_stall;
    // Input stage blocks only when it holds a word that cannot move on.
    assign in_stall = s1_valid_reg && !s2_load;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s2_load)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
        s2_valid_next = s2_load ? s1_valid_reg : s2_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_rand_reg  <= rand_value;
            s1_len_reg   <= pkt_len;
            s1_dport_reg <= dst_port;
        end
        if (s2_load && s1_valid_reg)
        begin
            s2_res_reg <= calc_res;
        end
    end

    assign out_valid    = s2_valid_reg;
    assign path_id      = s2_res_reg.path_id;
    assign src_port     = s2_res_reg.src_port;
    assign ip_total_len = s2_res_reg.ip_total_len;
    assign ip_checksum  = s2_res_reg.ip_checksum;
    assign udp_len      = s2_res_reg.udp_len;
    assign udp_checksum = s2_res_reg.udp_checksum;

endmodule

`default_nettype wire

FILE: src/whbld_checker.sv
// Port-level checks for the header builder, attached by bind.
// Depends on whbld_pkg and weighted_path_udp_header_builder.
`default_nettype none

module whbld_checker
    import whbld_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  in_stall,
    input wire logic                  out_valid,
    input wire logic                  out_stall,
    input wire logic [2:0]            path_id,
    input wire logic [10:0]           ip_total_len,
    input wire logic [10:0]           udp_len,
    input wire logic [15:0]           udp_checksum
);

    // input side backs up only when a result is held
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("in_stall without a held result");

    // held result stays put
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(udp_checksum) && $stable(path_id)))
        else $error("stalled result changed");

    // IP total length is UDP length plus the 20-byte IPv4 header
    a_len_rel: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ip_total_len == (udp_len + 11'd20)))
        else $error("length mismatch");

    a_udp_csum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (udp_checksum != 16'h0000))
        else $error("zero UDP checksum sent");

    a_path_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (path_id < 3'(MAX_PATHS)))
        else $error("path out of range");

endmodule

bind weighted_path_udp_header_builder whbld_checker u_whbld_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for weighted_path_udp_header_builder: directed path, length and
// checksum corner cases, then randomized routing settings and traffic with random idling.
// Depends on whbld_pkg and the builder RTL; results are checked against a local header model.

module tb;
    import whbld_pkg::*;

    localparam int          HALF_PERIOD    = 5;
    localparam int          RESET_CYCLES   = 12;
    localparam int          IDLE_MAX       = 12;
    localparam int          SETTLE_CYCLES  = 4;      // two-stage pipe, plus margin
    localparam int          WATCHDOG_LIMIT = 2000;   // well above the long hold-off
    localparam int          LONG_HOLD      = 200;
    localparam int          REPORT_LIMIT   = 10;
    localparam int          RANDOM_PHASES  = 6;
    localparam int          PHASE_WORDS    = 200;
    localparam logic [15:0] VER_IHL_TOS    = 16'h4500;
    localparam logic [15:0] IP_IDENT       = 16'd54321;
    localparam logic [7:0]  IP_TTL         = 8'd64;
    localparam logic [15:0] TTL_PROTO      = {IP_TTL, PROTO_UDP[7:0]};
    localparam logic [10:0] SHORT_FRAME    = HDR_FIXED + MIN_PAYLOAD;  // at or below: min payload

    // ------------------------------------------------------------------
    // DUT hookup
    // ------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    logic [9:0]            rand_value;
    logic [10:0]           pkt_len;
    logic [15:0]           dst_port;
    logic                  out_valid;
    logic                  out_stall;
    logic [2:0]            path_id;
    logic [15:0]           src_port;
    logic [10:0]           ip_total_len;
    logic [15:0]           ip_checksum;
    logic [10:0]           udp_len;
    logic [15:0]           udp_checksum;

    weighted_path_udp_header_builder DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rand_value   (rand_value),
        .pkt_len      (pkt_len),
        .dst_port     (dst_port),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .path_id      (path_id),
        .src_port     (src_port),
        .ip_total_len (ip_total_len),
        .ip_checksum  (ip_checksum),
        .udp_len      (udp_len),
        .udp_checksum (udp_checksum)
    );

    always #HALF_PERIOD clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow copy of the routing registers, starting from reset values
    // ------------------------------------------------------------------
    logic [31:0] rt_src_ip     = '0;
    logic [31:0] rt_dst_ip     = '0;
    logic [15:0] rt_port_base  = PORT_BASE_RST;
    logic [2:0]  rt_path_count = PATH_COUNT_RST;
    logic [9:0]  rt_cum [0:CUM_REGS-1] = '{PER_MILLE, PER_MILLE, PER_MILLE, PER_MILLE};

    res_t pending_headers [$];   // headers owed by the DUT, oldest first

    int fail_count;
    int headers_checked;
    int words_sent;
    int settings_used;
    int in_stall_cycles;
    int req_gap_max;             // sender idle draw per word, 0..IDLE_MAX
    int rsp_stall_max;           // receiver stall draw per word, 0..IDLE_MAX
    int hold_cycles;             // one-shot long receiver hold-off

    // ------------------------------------------------------------------
    // Header model
    // ------------------------------------------------------------------

    // End-around-carry sum folded to 16 bits, not inverted.
    function automatic logic [15:0] ones_fold(input logic [31:0] acc);
        logic [31:0] s;
        s = {16'h0, acc[31:16]} + {16'h0, acc[15:0]};
        s = {16'h0, s[31:16]} + {16'h0, s[15:0]};
        return s[15:0];
    endfunction

    // Address words shared by the IPv4 header and the UDP pseudo-header.
    function automatic logic [31:0] addr_word_sum();
        logic [31:0] s;
        s = {16'h0, rt_src_ip[31:16]} + {16'h0, rt_src_ip[15:0]}
          + {16'h0, rt_dst_ip[31:16]} + {16'h0, rt_dst_ip[15:0]};
        return s;
    endfunction

    function automatic res_t predict_header(input logic [9:0] rnd, input logic [10:0] len,
                                            input logic [15:0] dport);
        logic [9:0]  bound [0:MAX_PATHS];
        int unsigned cnt;
        logic [2:0]  pick;
        logic [10:0] payload;
        logic [31:0] ip_acc;
        logic [31:0] udp_acc;
        res_t        hdr;
        // count saturates at the path limit; zero scans nothing
        cnt      = (rt_path_count > MAX_PATHS) ? MAX_PATHS : rt_path_count;
        pick     = '0;
        bound[0] = '0;
        for (int i = 1; i <= MAX_PATHS; i++)
        begin
            if (i < cnt)
            begin
                bound[i] = (rt_cum[i-1] > PER_MILLE) ? PER_MILLE : rt_cum[i-1];
            end
            else
            begin
                bound[i] = PER_MILLE;
            end
        end
        // closed intervals; a shared edge goes to the later path
        for (int i = 0; i < cnt; i++)
        begin
            if (rnd >= bound[i] && rnd <= bound[i+1])
            begin
                pick = 3'(i);
            end
        end
        payload          = (len > SHORT_FRAME) ? len - HDR_FIXED : MIN_PAYLOAD;
        hdr.path_id      = pick;
        hdr.src_port     = rt_port_base + 16'(pick);
        hdr.ip_total_len = IP_UDP_HDRS + payload;
        hdr.udp_len      = UDP_HDR + payload;
        ip_acc           = 32'(VER_IHL_TOS) + 32'(hdr.ip_total_len) + 32'(IP_IDENT)
                         + 32'(TTL_PROTO) + addr_word_sum();
        hdr.ip_checksum  = ~ones_fold(ip_acc);
        udp_acc          = addr_word_sum() + 32'(PROTO_UDP) + 32'(hdr.udp_len)
                         + 32'(hdr.udp_len) + 32'(hdr.src_port) + 32'(dport);
        hdr.udp_checksum = ~ones_fold(udp_acc);
        if (hdr.udp_checksum == 16'h0000)
        begin
            hdr.udp_checksum = 16'hffff;   // zero means "no checksum" on the wire
        end
        return hdr;
    endfunction

    function automatic string fmt_header(input res_t h);
        return $sformatf("path %0d sport %h iplen %0d ipck %h udplen %0d udpck %h",
                         h.path_id, h.src_port, h.ip_total_len, h.ip_checksum,
                         h.udp_len, h.udp_checksum);
    endfunction

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_LIMIT)
        begin
            $display("%t ERROR %s", $realtime, what);
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall per word, plus the one-shot long hold-off
    // ------------------------------------------------------------------
    initial
    begin : result_sink
        int wait_n;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                wait_n = hold_cycles;
            end
            else if (rsp_stall_max > 0)
            begin
                wait_n = $urandom_range(0, rsp_stall_max);
            end
            else
            begin
                wait_n = 0;
            end
            hold_cycles = 0;
            if (wait_n > 0)
            begin
                out_stall <= 1'b1;
                repeat (wait_n) @(negedge clk);
            end
            out_stall <= 1'b0;
            // stall is low from here on, so the next valid word is taken
            @(posedge clk);
            while (!out_valid)
            begin
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Checker: every accepted header against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : header_check
        res_t want;
        res_t got;
        if (in_valid && in_stall)
        begin
            in_stall_cycles++;
        end
        if (rst_n && out_valid && !out_stall)
        begin
            got.path_id      = path_id;
            got.src_port     = src_port;
            got.ip_total_len = ip_total_len;
            got.ip_checksum  = ip_checksum;
            got.udp_len      = udp_len;
            got.udp_checksum = udp_checksum;
            headers_checked++;
            if (pending_headers.size() == 0)
            begin
                note_failure({"header with none pending: ", fmt_header(got)});
            end
            else
            begin
                want = pending_headers.pop_front();
                if (got.path_id !== want.path_id || got.src_port !== want.src_port ||
                    got.ip_total_len !== want.ip_total_len ||
                    got.ip_checksum !== want.ip_checksum ||
                    got.udp_len !== want.udp_len || got.udp_checksum !== want.udp_checksum)
                begin
                    note_failure({"header ", $sformatf("%0d", headers_checked),
                                  "\n  expected ", fmt_header(want),
                                  "\n  actual   ", fmt_header(got)});
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no word moving on either side
    // ------------------------------------------------------------------
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
            begin
                quiet = 0;
            end
            else
            begin
                quiet++;
            end
        end
        $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
        $display("weighted_path_udp_header_builder: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Request side. All tasks start and end just after a falling edge.
    // ------------------------------------------------------------------
    task automatic send_request(input logic [9:0] rnd, input logic [10:0] len,
                                input logic [15:0] dport);
        int gap;
        gap = (req_gap_max > 0) ? $urandom_range(0, req_gap_max) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        rand_value <= rnd;
        pkt_len    <= len;
        dst_port   <= dport;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        // config is frozen while words are in flight, so predict at accept
        pending_headers.push_back(predict_header(rnd, len, dport));
        words_sent++;
        @(negedge clk);
    endtask

    // Mostly in-range words; some out-of-range random values and frame lengths.
    task automatic send_random_request();
        logic [9:0]  rnd;
        logic [10:0] len;
        int          sel;
        rnd = ($urandom_range(0, 15) == 0) ? 10'($urandom_range(1000, 1023))
                                           : 10'($urandom_range(0, 999));
        sel = $urandom_range(0, 15);
        if (sel < 2)
        begin
            len = 11'($urandom_range(0, SHORT_FRAME));
        end
        else if (sel == 2)
        begin
            len = 11'($urandom_range(1501, 2047));
        end
        else
        begin
            len = 11'($urandom_range(SHORT_FRAME + 1, 1500));
        end
        send_request(rnd, len, 16'($urandom));
    endtask

    // Drop valid, wait for every owed header, then let the pipe settle.
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_headers.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes all eight registers back to back, only once the block is empty.
    task automatic set_config(input logic [31:0] src, input logic [31:0] dst,
                              input logic [15:0] base, input logic [2:0] count,
                              input logic [9:0] c1, input logic [9:0] c2,
                              input logic [9:0] c3, input logic [9:0] c4);
        logic [31:0] regs_image [0:7];
        wait_idle();
        regs_image[REG_SRC_IP]     = src;
        regs_image[REG_DST_IP]     = dst;
        regs_image[REG_PORT_BASE]  = {16'h0, base};
        regs_image[REG_PATH_COUNT] = {29'h0, count};
        regs_image[REG_CUM_1]      = {22'h0, c1};
        regs_image[REG_CUM_2]      = {22'h0, c2};
        regs_image[REG_CUM_3]      = {22'h0, c3};
        regs_image[REG_CUM_4]      = {22'h0, c4};
        cfg_we <= 1'b1;
        for (int i = REG_SRC_IP; i <= REG_CUM_4; i++)
        begin
            cfg_index <= cfg_index_t'(i);
            cfg_data  <= regs_image[i];
            @(negedge clk);
        end
        cfg_we <= 1'b0;
        rt_src_ip     = src;
        rt_dst_ip     = dst;
        rt_port_base  = base;
        rt_path_count = count;
        rt_cum[0]     = c1;
        rt_cum[1]     = c2;
        rt_cum[2]     = c3;
        rt_cum[3]     = c4;
        settings_used++;
    endtask

    // Mostly ordered splits; a quarter get arbitrary (possibly >1000) thresholds.
    task automatic pick_random_routing();
        logic [31:0] src;
        logic [31:0] dst;
        logic [15:0] base;
        logic [2:0]  count;
        logic [9:0]  t [0:CUM_REGS-1];
        src   = ($urandom_range(0, 7) == 0) ? 32'hffff_ffff : $urandom;
        dst   = ($urandom_range(0, 7) == 0) ? 32'h0 : $urandom;
        base  = ($urandom_range(0, 7) == 0) ? 16'hffff - 16'($urandom_range(0, 3))
                                            : 16'($urandom);
        count = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(0, 7))
                                            : 3'($urandom_range(1, 5));
        if ($urandom_range(0, 3) == 0)
        begin
            for (int i = 0; i < CUM_REGS; i++)
            begin
                t[i] = 10'($urandom_range(0, 1023));
            end
        end
        else
        begin
            t[0] = 10'($urandom_range(0, PER_MILLE));
            for (int i = 1; i < CUM_REGS; i++)
            begin
                t[i] = 10'($urandom_range(t[i-1], PER_MILLE));
            end
        end
        set_config(src, dst, base, count, t[0], t[1], t[2], t[3]);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset routing: one path over [0,1000], port base 8000, zero addresses.
    task automatic test_reset_defaults();
        send_request(10'd0, 11'd0, 16'h0000);
        send_request(10'd999, 11'd52, 16'hffff);       // last short frame
        send_request(10'd1023, 11'd53, 16'h5555);      // first longer frame, value past range
        send_request(10'd1000, 11'd2047, 16'haaaa);    // upper edge, unclipped frame
        send_request(10'd500, 11'd1500, 16'h1234);
    endtask

    // Five paths split evenly; values on the shared edges 200, 400 and 800 pick the later path.
    task automatic test_path_boundaries();
        set_config(32'h0a0b_0c0d, 32'h1122_3344, 16'd1000, 3'd5,
                   10'd200, 10'd400, 10'd600, 10'd800);
        send_request(10'd0, 11'd100, 16'd1);
        send_request(10'd200, 11'd300, 16'd2);
        send_request(10'd201, 11'd64, 16'd3);
        send_request(10'd400, 11'd700, 16'd4);
        send_request(10'd799, 11'd1400, 16'd5);
        send_request(10'd800, 11'd42, 16'd6);
        send_request(10'd999, 11'd1024, 16'd7);
        send_request(10'd1000, 11'd1500, 16'd8);
    endtask

    // Count and threshold saturation, zero count, wrapped source port, unordered split.
    task automatic test_saturation();
        set_config(32'hffff_ffff, 32'hffff_ffff, 16'hffff, 3'd7,
                   10'd1023, 10'd1023, 10'd1023, 10'd1023);
        send_request(10'd500, 11'd1500, 16'hffff);
        send_request(10'd1000, 11'd2047, 16'hffff);
        set_config(32'hffff_ffff, 32'h0, 16'hfffe, 3'd6, 10'd100, 10'd200, 10'd300, 10'd400);
        send_request(10'd999, 11'd900, 16'h8000);
        set_config(32'h0, 32'hffff_ffff, 16'h0, 3'd0, 10'd0, 10'd0, 10'd0, 10'd0);
        send_request(10'd1000, 11'd60, 16'h0001);
        send_request(10'd0, 11'd10, 16'h0000);
        // path 1 interval [800,300] is empty
        set_config(32'h1, 32'h2, 16'd3, 3'd3, 10'd800, 10'd300, PER_MILLE, PER_MILLE);
        send_request(10'd100, 11'd200, 16'h0f0f);
        send_request(10'd500, 11'd200, 16'hf0f0);
    endtask

    // Destination port chosen so the UDP sum folds to all ones.
    task automatic test_zero_udp_checksum();
        res_t        hdr;
        logic [31:0] acc;
        logic [15:0] dport;
        for (int k = 0; k < 2; k++)
        begin
            if (k == 0)
            begin
                set_config(32'h0, 32'h0, 16'h0, 3'd1, PER_MILLE, PER_MILLE, PER_MILLE, PER_MILLE);
            end
            else
            begin
                set_config(32'h0a0b_0c0d, 32'hfedc_ba98, 16'hbeef, 3'd2,
                           10'd500, PER_MILLE, PER_MILLE, PER_MILLE);
            end
            hdr   = predict_header(10'd700, 11'd600, 16'h0000);
            acc   = addr_word_sum() + 32'(PROTO_UDP) + 32'(hdr.udp_len) + 32'(hdr.udp_len)
                  + 32'(hdr.src_port);
            dport = 16'hffff - ones_fold(acc);
            send_request(10'd700, 11'd600, dport);
        end
    endtask

    // Receiver holds off long enough to back the input up; then the sender
    // drains completely before a second burst.
    task automatic test_backpressure();
        req_gap_max   = 0;
        rsp_stall_max = 0;
        pick_random_routing();
        hold_cycles = LONG_HOLD;
        repeat (40) send_random_request();
        wait_idle();
        repeat (20) send_random_request();
        wait_idle();
    endtask

    // Random routing per phase; idling mix changes from phase to phase.
    task automatic test_random_traffic();
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            case (phase % 4)
                0:
                begin
                    req_gap_max   = 0;
                    rsp_stall_max = 0;
                end
                1:
                begin
                    req_gap_max   = IDLE_MAX;
                    rsp_stall_max = IDLE_MAX;
                end
                2:
                begin
                    req_gap_max   = 0;
                    rsp_stall_max = IDLE_MAX;
                end
                default:
                begin
                    req_gap_max   = IDLE_MAX;
                    rsp_stall_max = 0;
                end
            endcase
            pick_random_routing();
            repeat (PHASE_WORDS) send_random_request();
        end
        wait_idle();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = REG_SRC_IP;
        cfg_data      = '0;
        in_valid      = 1'b0;
        rand_value    = '0;
        pkt_len       = '0;
        dst_port      = '0;
        req_gap_max   = 0;
        rsp_stall_max = 0;
        hold_cycles   = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_defaults();
        test_path_boundaries();
        test_saturation();
        test_zero_udp_checksum();
        test_backpressure();
        test_random_traffic();
        wait_idle();

        $display("run: %0d request words, %0d header words, %0d routing settings",
                 words_sent, headers_checked, settings_used);
        $display("run: input held off %0d cycles, %0d header errors",
                 in_stall_cycles, fail_count);
        if (fail_count == 0 && pending_headers.size() == 0)
        begin
            $display("weighted_path_udp_header_builder: match");
        end
        else
        begin
            $display("weighted_path_udp_header_builder: mismatch");
        end
        $finish;
    end

endmodule

FILE: weighted_path_udp_header_builder.f
src/whbld_pkg.sv
src/whbld_cfg_regs.sv
src/whbld_hdr_calc.sv
src/weighted_path_udp_header_builder.sv
src/whbld_checker.sv
tb/tb.sv
